// File: design/rfid_fd_pkg.sv
package rfid_fd_pkg;

   // actions carried by one input word
   typedef enum logic [1:0] {
      ACT_BYTE    = 2'd0,
      ACT_NEW_RUN = 2'd1,
      ACT_ABSENT  = 2'd2,
      ACT_RESTART = 2'd3
   } action_type;

   // reader type register codes
   localparam logic [1:0] READER_SHORT = 2'd0;
   localparam logic [1:0] READER_LONG  = 2'd1;
   localparam logic [1:0] READER_NONE  = 2'd2;

   // short range frame
   localparam int unsigned SR_PREFIX_LEN = 5;
   localparam logic [7:0] SR_PREFIX [SR_PREFIX_LEN] = '{8'h0E, 8'h00, 8'h11, 8'h00, 8'h05};
   localparam logic [3:0] SR_PREFIX_LAST_POS = 4'(SR_PREFIX_LEN - 1);
   localparam logic [3:0] SR_DATA_LAST_POS   = 4'd12;
   localparam logic [3:0] SR_CHECK_POS       = 4'd13;

   // long range frame
   localparam logic [7:0] LR_SOF         = 8'h54;
   localparam logic [3:0] LR_CRC_LO_POS  = 4'd9;
   localparam logic [3:0] LR_CRC_HI_POS  = 4'd10;

   // id bytes inside a frame, most significant last
   localparam int unsigned ID_FIRST_POS = 1;
   localparam int unsigned ID_LAST_POS  = 8;
   localparam int unsigned BYTE_STORE_LAST = 9;

   localparam logic [15:0] CRC_NIBBLE_MUL = 16'd4225;

   // queue between front and back
   localparam int unsigned QUEUE_DEPTH = 2;   // power of two
   localparam int unsigned QUEUE_AW    = $clog2(QUEUE_DEPTH);

   typedef struct packed {
      logic [1:0] action;
      logic [7:0] rx_byte;
      logic       framing_error;
      logic       parity_error;
   } req_word_type;

   typedef struct packed {
      logic        id_accepted;
      logic        checksum_error;
      logic        id_reported;
      logic [63:0] transponder_id;
      logic [15:0] framing_error_count;
      logic [15:0] parity_error_count;
   } rsp_word_type;

   typedef struct packed {
      action_type               action;
      logic [7:0]               rx_byte;
      logic                     framing_error;
      logic                     parity_error;
      logic [SR_PREFIX_LEN-1:0] sr_prefix_hit;
      logic                     lr_sof_hit;
   } queue_item_type;

   // reflected crc-16 (0x1021), one nibble
   function automatic logic [15:0] crc_add_nibble(input logic [15:0] crc,
                                                  input logic [3:0]  nib);
      logic [3:0]  idx;
      logic [19:0] prod;
      idx  = crc[3:0] ^ nib;
      prod = 20'(idx) * 20'(CRC_NIBBLE_MUL);
      return (crc >> 4) ^ prod[15:0];
   endfunction

   function automatic logic [15:0] crc_add_byte(input logic [15:0] crc,
                                                input logic [7:0]  data);
      return crc_add_nibble(crc_add_nibble(crc, data[3:0]), data[7:4]);
   endfunction

endpackage

// File: design/rfid_fd_front.sv
module rfid_fd_front
   import rfid_fd_pkg::*;
(
   input  logic           req_valid,
   output logic           req_ready,
   input  req_word_type   req_data,
   input  logic           queue_full,
   output logic           push,
   output queue_item_type push_item
);

   assign req_ready = !queue_full;
   assign push      = req_valid && !queue_full;

   // decode action and pre-match the byte against every prefix position and the long range start byte
   always_comb begin
      push_item.action        = action_type'(req_data.action);
      push_item.rx_byte       = req_data.rx_byte;
      push_item.framing_error = req_data.framing_error;
      push_item.parity_error  = req_data.parity_error;
      for (int i = 0; i < SR_PREFIX_LEN; i++) begin
         push_item.sr_prefix_hit[i] = (req_data.rx_byte == SR_PREFIX[i]);
      end
      push_item.lr_sof_hit = (req_data.rx_byte == LR_SOF);
   end

endmodule

// File: design/rfid_fd_queue.sv
module rfid_fd_queue
   import rfid_fd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           push,
   input  queue_item_type push_item,
   output logic           full,
   input  logic           pop,
   output logic           head_valid,
   output queue_item_type head_item
);

   queue_item_type      storage_ff [QUEUE_DEPTH];
   logic [QUEUE_AW-1:0] wr_ptr_ff, wr_ptr_in;
   logic [QUEUE_AW-1:0] rd_ptr_ff, rd_ptr_in;
   logic [QUEUE_AW:0]   count_ff, count_in;

   assign full       = (count_ff == (QUEUE_AW + 1)'(QUEUE_DEPTH));
   assign head_valid = (count_ff != '0);
   assign head_item  = storage_ff[rd_ptr_ff];

   always_comb begin
      wr_ptr_in = push ? QUEUE_AW'(wr_ptr_ff + 1'b1) : wr_ptr_ff;
      rd_ptr_in = pop  ? QUEUE_AW'(rd_ptr_ff + 1'b1) : rd_ptr_ff;
      unique case ({push, pop})
         2'b10:   count_in = (QUEUE_AW + 1)'(count_ff + 1'b1);
         2'b01:   count_in = (QUEUE_AW + 1)'(count_ff - 1'b1);
         default: count_in = count_ff;
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

   always_ff @(posedge clock) begin
      if (push) begin
         storage_ff[wr_ptr_ff] <= push_item;
      end
   end

endmodule

// File: design/rfid_fd_back.sv
module rfid_fd_back
   import rfid_fd_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic [1:0]     reader_type,
   input  logic           item_valid,
   input  queue_item_type item,
   output logic           pop,
   output logic           rsp_valid,
   input  logic           rsp_ready,
   output rsp_word_type   rsp_data
);

   logic [3:0]  frame_pos_ff, frame_pos_in;
   logic [7:0]  xor_sum_ff, xor_sum_in;
   logic [15:0] crc_ff, crc_in;
   logic [63:0] stored_id_ff, stored_id_in;
   logic        id_valid_ff, id_valid_in;
   logic        new_run_ff, new_run_in;
   logic [15:0] fe_count_ff, fe_count_in;
   logic [15:0] pe_count_ff, pe_count_in;
   logic        rsp_valid_ff;
   rsp_word_type rsp_ff, rsp_in;
   logic [7:0]  frame_bytes_ff [ID_FIRST_POS:BYTE_STORE_LAST];

   logic        accepted;
   logic        cerr;
   logic        reported;
   logic [63:0] frame_id;
   logic [15:0] rx_crc;

   assign pop       = item_valid && (!rsp_valid_ff || rsp_ready);
   assign rsp_valid = rsp_valid_ff;
   assign rsp_data  = rsp_ff;

   always_comb begin
      frame_id = '0;
      for (int i = ID_LAST_POS; i >= ID_FIRST_POS; i--) begin
         frame_id = {frame_id[55:0], frame_bytes_ff[i]};
      end
   end

   assign rx_crc = {item.rx_byte, frame_bytes_ff[BYTE_STORE_LAST]};

   always_comb begin
      frame_pos_in = frame_pos_ff;
      xor_sum_in   = xor_sum_ff;
      crc_in       = crc_ff;
      stored_id_in = stored_id_ff;
      id_valid_in  = id_valid_ff;
      new_run_in   = new_run_ff;
      fe_count_in  = fe_count_ff;
      pe_count_in  = pe_count_ff;
      accepted     = 1'b0;
      cerr         = 1'b0;
      reported     = 1'b0;

      if (pop) begin
         unique case (item.action)
            ACT_BYTE: begin
               fe_count_in = 16'(fe_count_ff + 16'(item.framing_error));
               pe_count_in = 16'(pe_count_ff + 16'(item.parity_error));
               unique case (reader_type)
                  READER_SHORT: begin
                     if (frame_pos_ff <= SR_PREFIX_LAST_POS) begin
                        if (frame_pos_ff == 4'd0) begin
                           xor_sum_in = '0;
                        end
                        if (!item.sr_prefix_hit[frame_pos_ff[2:0]]) begin
                           frame_pos_in = '0;
                        end else begin
                           xor_sum_in   = xor_sum_in ^ item.rx_byte;
                           frame_pos_in = 4'(frame_pos_ff + 1'b1);
                        end
                     end else if (frame_pos_ff <= SR_DATA_LAST_POS) begin
                        xor_sum_in   = xor_sum_ff ^ item.rx_byte;
                        frame_pos_in = 4'(frame_pos_ff + 1'b1);
                     end else if (frame_pos_ff == SR_CHECK_POS) begin
                        cerr         = (item.rx_byte != xor_sum_ff);
                        accepted     = (item.rx_byte == xor_sum_ff);
                        frame_pos_in = '0;
                     end else begin
                        frame_pos_in = '0;
                     end
                  end
                  READER_LONG: begin
                     if (frame_pos_ff == 4'd0) begin
                        if (item.lr_sof_hit) begin
                           crc_in       = crc_add_byte('0, item.rx_byte);
                           frame_pos_in = 4'd1;
                        end
                     end else if (frame_pos_ff == 4'd1) begin
                        crc_in       = crc_add_byte('0, item.rx_byte);
                        frame_pos_in = 4'(frame_pos_ff + 1'b1);
                     end else if (frame_pos_ff <= 4'(ID_LAST_POS)) begin
                        crc_in       = crc_add_byte(crc_ff, item.rx_byte);
                        frame_pos_in = 4'(frame_pos_ff + 1'b1);
                     end else if (frame_pos_ff == LR_CRC_LO_POS) begin
                        frame_pos_in = 4'(frame_pos_ff + 1'b1);
                     end else if (frame_pos_ff == LR_CRC_HI_POS) begin
                        cerr         = (rx_crc != crc_ff);
                        accepted     = (rx_crc == crc_ff);
                        frame_pos_in = '0;
                     end else begin
                        frame_pos_in = '0;
                     end
                  end
                  default: frame_pos_in = '0;
               endcase
               if (accepted && (new_run_ff || !id_valid_ff || frame_id != stored_id_ff)) begin
                  new_run_in   = 1'b0;
                  stored_id_in = frame_id;
                  id_valid_in  = 1'b1;
                  reported     = 1'b1;
               end
            end
            ACT_NEW_RUN: new_run_in = 1'b1;
            ACT_ABSENT: begin
               id_valid_in  = 1'b0;
               stored_id_in = '0;
            end
            ACT_RESTART: frame_pos_in = '0;
         endcase
      end

      rsp_in.id_accepted         = accepted;
      rsp_in.checksum_error      = cerr;
      rsp_in.id_reported         = reported;
      rsp_in.transponder_id      = id_valid_in ? stored_id_in : '0;
      rsp_in.framing_error_count = fe_count_in;
      rsp_in.parity_error_count  = pe_count_in;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         frame_pos_ff <= '0;
         xor_sum_ff   <= '0;
         crc_ff       <= '0;
         stored_id_ff <= '0;
         id_valid_ff  <= 1'b0;
         new_run_ff   <= 1'b0;
         fe_count_ff  <= '0;
         pe_count_ff  <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         frame_pos_ff <= frame_pos_in;
         xor_sum_ff   <= xor_sum_in;
         crc_ff       <= crc_in;
         stored_id_ff <= stored_id_in;
         id_valid_ff  <= id_valid_in;
         new_run_ff   <= new_run_in;
         fe_count_ff  <= fe_count_in;
         pe_count_ff  <= pe_count_in;
         if (pop) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_ready) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // frame byte store and result register, no reset
   always_ff @(posedge clock) begin
      if (pop) begin
         rsp_ff <= rsp_in;
      end
      for (int i = ID_FIRST_POS; i <= BYTE_STORE_LAST; i++) begin
         if (pop && item.action == ACT_BYTE && frame_pos_ff == 4'(i)) begin
            frame_bytes_ff[i] <= item.rx_byte;
         end
      end
   end

endmodule

// File: design/rfid_id_frame_decoder_core.sv
// transponder id frame decoder: takes one uart word per cycle while req_ready is high
// (a data byte with its framing and parity error flags, or a new-run / transponder-absent
// / restart-frame action) and returns exactly one result word for each, in order.
// csr_write_data picks the reader: 0 short range (prefix 0e 00 11 00 05, 14 bytes, xor
// check on the last byte), 1 long range (start byte 54, 11 bytes, crc-16 kermit over
// bytes 1 to 8 against bytes 9 and 10 low first), 2 none. a good frame yields the
// 64-bit id from bytes 8 down to 1; id_reported is set when that id is new or a new
// run was requested. both error counters wrap at 16 bits. the csr may be written only
// while the block is idle. an accepted word is written into the 2-entry queue and
// moves into the result register when the back pops it; the queue lets the front
// keep taking words while a result waits on rsp_ready.
module rfid_id_frame_decoder_core
   import rfid_fd_pkg::*;
(
   input  logic         clock,
   input  logic         reset,
   input  logic         csr_write_enable,
   input  logic [1:0]   csr_write_data,
   input  logic         req_valid,
   output logic         req_ready,
   input  req_word_type req_data,
   output logic         rsp_valid,
   input  logic         rsp_ready,
   output rsp_word_type rsp_data
);

   logic [1:0]     reader_type_q_ff;
   logic           queue_full;
   logic           push;
   queue_item_type push_item;
   logic           pop;
   logic           head_valid;
   queue_item_type head_item;

   // reader type register
   always_ff @(posedge clock) begin
      if (reset) begin
         reader_type_q_ff <= READER_SHORT;
      end else if (csr_write_enable) begin
         reader_type_q_ff <= csr_write_data;
      end
   end

   // front: handshake and byte pre-classification
   rfid_fd_front u_front (
      .req_valid  (req_valid),
      .req_ready  (req_ready),
      .req_data   (req_data),
      .queue_full (queue_full),
      .push       (push),
      .push_item  (push_item)
   );

   // short queue between front and back
   rfid_fd_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push       (push),
      .push_item  (push_item),
      .full       (queue_full),
      .pop        (pop),
      .head_valid (head_valid),
      .head_item  (head_item)
   );

   // back: frame state machine, id store, counters, result register
   rfid_fd_back u_back (
      .clock       (clock),
      .reset       (reset),
      .reader_type (reader_type_q_ff),
      .item_valid  (head_valid),
      .item        (head_item),
      .pop         (pop),
      .rsp_valid   (rsp_valid),
      .rsp_ready   (rsp_ready),
      .rsp_data    (rsp_data)
   );

   // a completed frame is either good or bad, never both
   a_accept_xor_error: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !(rsp_data.id_accepted && rsp_data.checksum_error))
      else $error("frame flagged both accepted and checksum error");

   // an id is only reported from an accepted frame, and it is then the stored id
   a_report_needs_accept: assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_data.id_reported) |-> rsp_data.id_accepted)
      else $error("id reported without an accepted frame");

   // the front only stalls when there is work waiting for the back
   a_stall_has_work: assert property (@(posedge clock) disable iff (reset)
      !req_ready |-> head_valid)
      else $error("input stalled with an empty queue");

   // a popped word always lands in the result register
   a_pop_fills_rsp: assert property (@(posedge clock) disable iff (reset)
      pop |=> rsp_valid)
      else $error("popped word produced no result");

endmodule
